>>> hdl/ffpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit page allocator package
// Shared sizes, flag codes, register indexes and the structs that pass
// between the sequencer, the flag memory and the top level.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Page table geometry.
    localparam int PAGE_TOTAL = 256;
    localparam int IDX_W      = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;
    localparam int CNT_W      = $clog2(PAGE_TOTAL + 1);

    // Field and register widths.
    localparam int ADDR_W       = 32;
    localparam int SHIFT_W      = 5;
    localparam int PAGE_COUNT_W = 9;
    localparam int FIRST_PAGE_W = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // Per-page flag codes: bit 0 is taken, bit 1 marks the last page of a run.
    localparam int FLAG_W = 2;
    localparam logic [FLAG_W-1:0] FLAG_EMPTY = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_LAST  = 2'b10;

    // Request function codes.
    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'b1;
    localparam logic [ADDR_W-1:0]    ALLOC_BASE_RESET = '0;
    localparam logic [SHIFT_W-1:0]   PAGE_SHIFT_RESET = 5'd10;

    // Access from the sequencer to the flag memory.
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [FLAG_W-1:0] wr_data;
    } t_mem_req;

    // Completed request from the sequencer to the output stage.
    typedef struct packed {
        logic             done;
        logic             success;
        logic             has_addr;
        logic [IDX_W-1:0] start;
    } t_result;

endpackage

>>> hdl/ffpa_flag_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page flag memory
// Synchronous flag table with one write and one registered read per cycle.
// A valid bit per page lets a clear request empty the whole table at once.
// ----------------------------------------------------------------------------
module ffpa_flag_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffpa_pkg::t_mem_req             i_req,
    output logic [ffpa_pkg::FLAG_W-1:0]    o_rd_flags
);

    logic [ffpa_pkg::FLAG_W-1:0] r_mem [ffpa_pkg::PAGE_TOTAL];
    logic [ffpa_pkg::PAGE_TOTAL-1:0] r_valid;
    logic [ffpa_pkg::FLAG_W-1:0] r_rd_data;
    logic                        r_rd_valid;

    // Flag storage: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    // Valid bits: reset and clear empty every page at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // A page never written since the last clear reads as empty.
    assign o_rd_flags = r_rd_valid ? r_rd_data : ffpa_pkg::FLAG_EMPTY;

    // A clear never coincides with a flag write.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.clear && i_req.wr_en))
        else $error("flag write during clear");

    // A read and a write never target the table in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.rd_en && i_req.wr_en))
        else $error("flag read and write overlap");

endmodule

>>> hdl/ffpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation sequencer
// Scans the flag memory from page 0 one page per cycle, then marks the
// found run taken one page per cycle and reports the result.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                i_func,
    input  logic [ffpa_pkg::PAGE_COUNT_W-1:0]   i_page_count,
    input  logic [ffpa_pkg::FLAG_W-1:0]         i_rd_flags,
    output logic                                busy,
    output ffpa_pkg::t_mem_req                  o_mem,
    output ffpa_pkg::t_result                   o_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    localparam logic [ffpa_pkg::IDX_W-1:0] LAST_IDX =
        ffpa_pkg::IDX_W'(ffpa_pkg::PAGE_TOTAL - 1);

    logic [1:0]                   r_state, n_state;
    logic [ffpa_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [ffpa_pkg::CNT_W-1:0]   r_run, n_run;
    logic [ffpa_pkg::CNT_W-1:0]   r_count, n_count;
    logic [ffpa_pkg::IDX_W-1:0]   r_wr_idx, n_wr_idx;
    logic [ffpa_pkg::IDX_W-1:0]   r_end, n_end;
    logic [ffpa_pkg::IDX_W-1:0]   r_start, n_start;
    ffpa_pkg::t_result            r_res, n_res;
    logic                         accept;
    logic                         count_bad;
    logic [ffpa_pkg::CNT_W-1:0]   run_next;
    logic [ffpa_pkg::IDX_W-1:0]   found_start;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_res  = r_res;

    assign count_bad = (i_page_count == '0) ||
                       (32'(i_page_count) > 32'(ffpa_pkg::PAGE_TOTAL));
    assign run_next  = (i_rd_flags == ffpa_pkg::FLAG_EMPTY) ?
                       r_run + ffpa_pkg::CNT_W'(1) : '0;
    assign found_start = ffpa_pkg::IDX_W'(32'(r_idx) + 32'd1 - 32'(r_count));

    // Next-state logic for the scan and mark sequence.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_run    = r_run;
        n_count  = r_count;
        n_wr_idx = r_wr_idx;
        n_end    = r_end;
        n_start  = r_start;
        n_res    = '0;
        o_mem    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == ffpa_pkg::FUNC_CLEAR) begin
                        o_mem.clear   = 1'b1;
                        n_res.done    = 1'b1;
                        n_res.success = 1'b1;
                    end else if (count_bad) begin
                        n_res.done = 1'b1;
                    end else begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = '0;
                        n_idx   = '0;
                        n_run   = '0;
                        n_count = ffpa_pkg::CNT_W'(i_page_count);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Data for page r_idx arrives now; fetch the next page.
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_idx + ffpa_pkg::IDX_W'(1);
                n_run = run_next;
                if (run_next == r_count) begin
                    n_start  = found_start;
                    n_wr_idx = found_start;
                    n_end    = r_idx;
                    n_state  = S_WRITE;
                end else if (r_idx == LAST_IDX) begin
                    n_res.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_idx = r_idx + ffpa_pkg::IDX_W'(1);
                end
            end
            S_WRITE: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_wr_idx;
                if (r_wr_idx == r_end) begin
                    o_mem.wr_data  = ffpa_pkg::FLAG_TAKEN | ffpa_pkg::FLAG_LAST;
                    n_res.done     = 1'b1;
                    n_res.success  = 1'b1;
                    n_res.has_addr = 1'b1;
                    n_res.start    = r_start;
                    n_state        = S_IDLE;
                end else begin
                    o_mem.wr_data = ffpa_pkg::FLAG_TAKEN;
                    n_wr_idx      = r_wr_idx + ffpa_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Scan and mark bookkeeping.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_run    <= n_run;
        r_count  <= n_count;
        r_wr_idx <= n_wr_idx;
        r_end    <= n_end;
        r_start  <= n_start;
    end

    // The mark pass never runs past the last page of the found run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_wr_idx <= r_end))
        else $error("mark pass overran its run");

    // A clear or a rejected count reports in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == ffpa_pkg::FUNC_CLEAR || count_bad)) |=>
        (r_res.done && !busy))
        else $error("immediate request did not report");

    // An address is only ever reported with a successful result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.done && r_res.has_addr) |-> r_res.success)
        else $error("address reported without success");

endmodule

>>> hdl/first_fit_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit page allocator
// Keeps a taken flag and a last-of-run flag per page and hands out the
// lowest-addressed run of free pages that fits each allocate request.
// ----------------------------------------------------------------------------
// Each request returns exactly one result, shown for one cycle on o_strobe;
// the receiver must take it then. A clear request or an allocate request
// with a count of zero or above the table size reports from idle through
// the sequencer's result register and then the output register. An
// allocate request scans the flag memory from page 0, one page per cycle
// through its registered read port, until the run is found or the table
// is exhausted; a found run is then marked one page per cycle. busy is
// high only while a scan or mark pass runs, so a new request may be
// accepted while the previous result is still on its way to the output;
// results always leave in request order.
// Configuration writes take effect at once and must only be made while idle.
// ----------------------------------------------------------------------------
module first_fit_page_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [ffpa_pkg::PAGE_COUNT_W-1:0]   i_page_count,
    output logic                                o_strobe,
    output logic [ffpa_pkg::ADDR_W-1:0]         o_address,
    output logic [ffpa_pkg::FIRST_PAGE_W-1:0]   o_first_page,
    output logic                                o_success,
    input  logic                                i_cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ffpa_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [ffpa_pkg::ADDR_W-1:0]       r_alloc_base;
    logic [ffpa_pkg::SHIFT_W-1:0]      r_page_shift;
    logic                              r_strobe;
    logic [ffpa_pkg::ADDR_W-1:0]       r_address;
    logic [ffpa_pkg::FIRST_PAGE_W-1:0] r_first_page;
    logic                              r_success;
    ffpa_pkg::t_mem_req                mem_req;
    ffpa_pkg::t_result                 res;
    logic [ffpa_pkg::FLAG_W-1:0]       rd_flags;
    logic [ffpa_pkg::ADDR_W-1:0]       run_address;

    // Sequencer and flag memory.
    ffpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_func       (i_func),
        .i_page_count (i_page_count),
        .i_rd_flags   (rd_flags),
        .busy         (busy),
        .o_mem        (mem_req),
        .o_res        (res)
    );

    ffpa_flag_mem u_flag_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd_flags (rd_flags)
    );

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_base <= ffpa_pkg::ALLOC_BASE_RESET;
            r_page_shift <= ffpa_pkg::PAGE_SHIFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ffpa_pkg::CFG_ALLOC_BASE: begin
                    r_alloc_base <= ffpa_pkg::ADDR_W'(i_cfg_wdata);
                end
                ffpa_pkg::CFG_PAGE_SHIFT: begin
                    r_page_shift <= i_cfg_wdata[ffpa_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Start address of the run, wrapping modulo 2^32.
    assign run_address = r_alloc_base +
                         (ffpa_pkg::ADDR_W'(res.start) << r_page_shift);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_address    <= res.has_addr ? run_address : '0;
        r_first_page <= ffpa_pkg::FIRST_PAGE_W'(res.start);
        r_success    <= res.success;
    end

    assign o_strobe     = r_strobe;
    assign o_address    = r_address;
    assign o_first_page = r_first_page;
    assign o_success    = r_success;

    // A failed request carries neither an address nor a page index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_success) |-> (o_address == '0 && o_first_page == '0))
        else $error("failure result carries data");

endmodule

>>> verif/first_fit_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Drives clear and allocate requests through the start/busy handshake and
// checks every strobed result against a shadow page table kept here. The
// base address and page shift change between phases, extremes included,
// while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_tb;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic                              func;
        logic [ffpa_pkg::PAGE_COUNT_W-1:0] count;
    } t_page_req;

    typedef struct packed {
        logic [ffpa_pkg::ADDR_W-1:0]       address;
        logic [ffpa_pkg::FIRST_PAGE_W-1:0] first_page;
        logic                              success;
    } t_alloc_result;

    // Block ports.
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              i_func = ffpa_pkg::FUNC_CLEAR;
    logic [ffpa_pkg::PAGE_COUNT_W-1:0] i_page_count = '0;
    logic                              o_strobe;
    logic [ffpa_pkg::ADDR_W-1:0]       o_address;
    logic [ffpa_pkg::FIRST_PAGE_W-1:0] o_first_page;
    logic                              o_success;
    logic                              i_cfg_we = 1'b0;
    logic [ffpa_pkg::CFG_IDX_W-1:0]    i_cfg_index = ffpa_pkg::CFG_ALLOC_BASE;
    logic [ffpa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    // Shadow page table and registers.
    logic [ffpa_pkg::FLAG_W-1:0]  shadow_flags [ffpa_pkg::PAGE_TOTAL];
    logic [ffpa_pkg::ADDR_W-1:0]  shadow_base = ffpa_pkg::ALLOC_BASE_RESET;
    logic [ffpa_pkg::SHIFT_W-1:0] shadow_shift = ffpa_pkg::PAGE_SHIFT_RESET;

    t_page_req     pending_requests [$];
    t_alloc_result expected_results [$];
    t_page_req     next_req;
    t_alloc_result want;

    bit req_taken = 1'b0;
    bit no_gaps = 1'b0;
    int gap_left = 0;
    int err_count = 0;
    int idle_cycles = 0;

    first_fit_page_allocator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_page_count (i_page_count),
        .o_strobe     (o_strobe),
        .o_address    (o_address),
        .o_first_page (o_first_page),
        .o_success    (o_success),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        for (int p = 0; p < ffpa_pkg::PAGE_TOTAL; p++) begin
            shadow_flags[p] = ffpa_pkg::FLAG_EMPTY;
        end
    end

    // First-fit scan over the shadow table; updates the table as the block would.
    function automatic t_alloc_result predict_allocation(t_page_req req);
        t_alloc_result res;
        int            run;
        int            first;
        logic [63:0]   sum;
        res = '0;
        if (req.func == ffpa_pkg::FUNC_CLEAR) begin
            for (int p = 0; p < ffpa_pkg::PAGE_TOTAL; p++) begin
                shadow_flags[p] = ffpa_pkg::FLAG_EMPTY;
            end
            res.success = 1'b1;
            return res;
        end
        if (req.count == 0 || req.count > ffpa_pkg::PAGE_TOTAL) begin
            return res;
        end
        run = 0;
        for (int i = 0; i < ffpa_pkg::PAGE_TOTAL; i++) begin
            if (shadow_flags[i] == ffpa_pkg::FLAG_EMPTY) begin
                run++;
            end else begin
                run = 0;
            end
            if (run == req.count) begin
                first = i + 1 - req.count;
                for (int j = first; j < i; j++) begin
                    shadow_flags[j] = ffpa_pkg::FLAG_TAKEN;
                end
                shadow_flags[i] = ffpa_pkg::FLAG_TAKEN | ffpa_pkg::FLAG_LAST;
                sum = {32'd0, shadow_base} + (64'(first) << shadow_shift);
                res.address    = sum[ffpa_pkg::ADDR_W-1:0];
                res.first_page = first[ffpa_pkg::FIRST_PAGE_W-1:0];
                res.success    = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    // Mostly back-to-back requests, some short pauses, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
        err_count++;
    endtask

    task automatic push_req(input logic func, input int count);
        pending_requests.push_back(
            '{func: func, count: count[ffpa_pkg::PAGE_COUNT_W-1:0]});
    endtask

    // Random count: mostly small runs, some large, a few that must fail outright.
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 10) return $urandom_range(ffpa_pkg::PAGE_TOTAL + 1, 511);
        if (r < 55) return $urandom_range(1, 8);
        if (r < 80) return $urandom_range(9, 32);
        if (r < 93) return $urandom_range(33, 128);
        return $urandom_range(129, ffpa_pkg::PAGE_TOTAL);
    endfunction

    // Sequences of a clear followed by random allocations, with an occasional extra clear.
    task automatic queue_random_requests(input int n);
        int left;
        int seq_len;
        left = n;
        while (left > 0) begin
            push_req(ffpa_pkg::FUNC_CLEAR, $urandom_range(0, 511));
            left--;
            seq_len = $urandom_range(1, 24);
            while (seq_len > 0 && left > 0) begin
                if ($urandom_range(0, 99) < 4) begin
                    push_req(ffpa_pkg::FUNC_CLEAR, $urandom_range(0, 511));
                end else begin
                    push_req(ffpa_pkg::FUNC_ALLOC, pick_count());
                end
                seq_len--;
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (!(pending_requests.size() == 0 && !start &&
                 expected_results.size() == 0 && !busy)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input logic [ffpa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ffpa_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [ffpa_pkg::ADDR_W-1:0] base,
                             input int shift, input int n);
        wait_drained();
        write_cfg(ffpa_pkg::CFG_ALLOC_BASE, base);
        write_cfg(ffpa_pkg::CFG_PAGE_SHIFT,
                  {(ffpa_pkg::CFG_DATA_W - ffpa_pkg::SHIFT_W)'($urandom()),
                   shift[ffpa_pkg::SHIFT_W-1:0]});
        @(posedge i_clk);
        no_gaps = ($urandom_range(0, 3) == 0);
        queue_random_requests(n / 2);
        // Hold the sender off until every result is back.
        wait_drained();
        queue_random_requests(n - n / 2);
    endtask

    // Request driver: changes inputs at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                next_req = pending_requests.pop_front();
                i_func       <= next_req.func;
                i_page_count <= next_req.count;
                start        <= 1'b1;
                gap_left     = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, tracks register writes, predicts accepted requests.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending", o_address,
                                    32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_address !== want.address)
                        report_mismatch("address", o_address, want.address);
                    if (o_first_page !== want.first_page)
                        report_mismatch("first_page", 32'(o_first_page),
                                        32'(want.first_page));
                    if (o_success !== want.success)
                        report_mismatch("success", 32'(o_success),
                                        32'(want.success));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == ffpa_pkg::CFG_ALLOC_BASE) begin
                    shadow_base = i_cfg_wdata[ffpa_pkg::ADDR_W-1:0];
                end else if (i_cfg_index == ffpa_pkg::CFG_PAGE_SHIFT) begin
                    shadow_shift = i_cfg_wdata[ffpa_pkg::SHIFT_W-1:0];
                end
            end
            req_taken = start && !busy;
            if (req_taken) begin
                expected_results.push_back(
                    predict_allocation('{func: i_func, count: i_page_count}));
            end
        end else begin
            req_taken = 1'b0;
        end
    end

    // Watchdog on cycles with neither a request nor a result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("first_fit_page_allocator_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad counts, full table, exact fits, top page.
        push_req(ffpa_pkg::FUNC_ALLOC, 0);
        push_req(ffpa_pkg::FUNC_ALLOC, ffpa_pkg::PAGE_TOTAL + 1);
        push_req(ffpa_pkg::FUNC_ALLOC, 511);
        push_req(ffpa_pkg::FUNC_ALLOC, 1);
        push_req(ffpa_pkg::FUNC_ALLOC, ffpa_pkg::PAGE_TOTAL);
        push_req(ffpa_pkg::FUNC_CLEAR, 511);
        push_req(ffpa_pkg::FUNC_ALLOC, ffpa_pkg::PAGE_TOTAL);
        push_req(ffpa_pkg::FUNC_ALLOC, 1);
        push_req(ffpa_pkg::FUNC_CLEAR, 0);
        push_req(ffpa_pkg::FUNC_ALLOC, 3);
        push_req(ffpa_pkg::FUNC_ALLOC, 5);
        push_req(ffpa_pkg::FUNC_ALLOC, 2);
        push_req(ffpa_pkg::FUNC_CLEAR, 256);
        push_req(ffpa_pkg::FUNC_ALLOC, ffpa_pkg::PAGE_TOTAL - 1);
        push_req(ffpa_pkg::FUNC_ALLOC, 1);
        push_req(ffpa_pkg::FUNC_ALLOC, 1);
        push_req(ffpa_pkg::FUNC_CLEAR, 85);
        push_req(ffpa_pkg::FUNC_ALLOC, 128);
        push_req(ffpa_pkg::FUNC_ALLOC, 128);
        push_req(ffpa_pkg::FUNC_ALLOC, 1);

        // Register extremes first, then random settings.
        run_phase(32'hFFFF_FFFF, 31, 150);
        run_phase(32'h0000_0000, 0, 150);
        run_phase($urandom(), 16, 150);
        run_phase($urandom(), 2, 150);
        run_phase(32'hFFFF_F000, 10, 150);
        for (int k = 0; k < 4; k++) begin
            run_phase($urandom(), $urandom_range(0, 31), 150);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("first_fit_page_allocator_tb: clean");
        end else begin
            $display("first_fit_page_allocator_tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/ffpa_pkg.sv
hdl/ffpa_flag_mem.sv
hdl/ffpa_ctrl.sv
hdl/first_fit_page_allocator.sv
verif/first_fit_page_allocator_tb.sv
